FILE: sv/chs_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash set package
// Shared constants, operation and status codes, and the queue item type.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int CHS_MAX_BUCKET_LOG2 = 10;
  localparam int CHS_NODE_CAPACITY   = 1024;
  localparam int CHS_RESET_LOG2      = 7;
  localparam int CHS_QUEUE_DEPTH     = 4;

  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_RESIZED   = 3'd1;
  localparam logic [2:0] ST_CONTAINED = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] hash;
  } item_t;

endpackage

FILE: sv/chained_hash_set_of_ids_unit.sv
// ----------------------------------------------------------------------------
// Chained hash set of ids
// Keeps a set of 32-bit ids in a chained hash table with on-demand growth.
// ----------------------------------------------------------------------------
// A three-stage hash front end feeds a four-item queue; the table engine then
// takes one item at a time. A lookup or insert in the engine reads its chain
// nodes one per cycle from the node memory's single read port. A clear
// sweeps 2^log2 bucket heads, one a cycle. An insert that grows the table
// sweeps 2^(log2+1) heads and then relinks every stored node, stepping it
// through S_RL_HASH, S_RL_HEAD and S_RL_LINK in turn. After reset and after
// each configuration write the 2^log2 bucket heads (128 by default) are
// swept before the first item is taken; the configuration port is always
// ready.
module chained_hash_set_of_ids_unit
  import chs_pkg::*;
#(
  parameter int MAX_BUCKET_LOG2 = CHS_MAX_BUCKET_LOG2,
  parameter int NODE_CAPACITY   = CHS_NODE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [10:0] out_element_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_initial_bucket_log2
);

  logic  push, q_ready, pop, q_valid;
  item_t push_item, q_item;

  assign cfg_ready = 1'b1;

  chs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key       (in_key),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  chs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  chs_back #(
    .MAX_BUCKET_LOG2 (MAX_BUCKET_LOG2),
    .NODE_CAPACITY   (NODE_CAPACITY)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_value         (cfg_initial_bucket_log2),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_element_count (out_element_count)
  );

endmodule

FILE: sv/chs_front.sv
// ----------------------------------------------------------------------------
// Chained hash set front end
// Accepts items and computes the fmix32 hash of the key in three stages.
// ----------------------------------------------------------------------------
module chs_front
  import chs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_key,
  output logic        push,
  output item_t       push_item,
  input  logic        q_ready
);

  logic        v1_r, v2_r, v3_r;
  logic [1:0]  op1_r, op2_r, op3_r;
  logic [31:0] key1_r, key2_r, key3_r;
  logic [31:0] h1_r, h2_r, h3_r;
  logic        adv1, adv2, adv3;
  logic [31:0] h2x;

  assign adv3     = !v3_r || q_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign push     = v3_r && q_ready;
  assign h2x      = h2_r ^ (h2_r >> 13);

  always_comb begin
    push_item.op   = op3_r;
    push_item.key  = key3_r;
    push_item.hash = h3_r ^ (h3_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1_r  <= in_operation;
      key1_r <= in_key;
      h1_r   <= in_key ^ (in_key >> 16);
    end
    if (adv2) begin
      op2_r  <= op1_r;
      key2_r <= key1_r;
      h2_r   <= 32'(h1_r * MIX_C1);
    end
    if (adv3) begin
      op3_r  <= op2_r;
      key3_r <= key2_r;
      h3_r   <= 32'(h2x * MIX_C2);
    end
  end

endmodule

FILE: sv/chs_queue.sv
// ----------------------------------------------------------------------------
// Chained hash set item queue
// A short FIFO that lets the hash front end and the table engine stall apart.
// ----------------------------------------------------------------------------
module chs_queue
  import chs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  q_ready,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  localparam int PTR_W = $clog2(CHS_QUEUE_DEPTH);

  item_t            slots_r [CHS_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign q_ready = cnt_r != (PTR_W+1)'(CHS_QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_item  = slots_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_r] <= push_item;
  end

endmodule

FILE: sv/chs_back.sv
// ----------------------------------------------------------------------------
// Chained hash set table engine
// Walks bucket chains, adds nodes, clears buckets and rebuilds on growth.
// ----------------------------------------------------------------------------
module chs_back
  import chs_pkg::*;
#(
  parameter int MAX_BUCKET_LOG2 = CHS_MAX_BUCKET_LOG2,
  parameter int NODE_CAPACITY   = CHS_NODE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [10:0] out_element_count
);

  localparam int MAXL    = MAX_BUCKET_LOG2;
  localparam int BKT_N   = 1 << MAXL;
  localparam int NODE_W  = $clog2(NODE_CAPACITY);
  localparam int CNT_W   = $clog2(NODE_CAPACITY + 1);
  localparam int LOG_W   = $clog2(MAXL + 1);
  localparam int LOAD_W  = (CNT_W > MAXL) ? CNT_W + 2 : MAXL + 2;
  localparam int RST_LOG = (CHS_RESET_LOG2 < MAXL) ? CHS_RESET_LOG2 : MAXL;

  typedef enum logic [8:0] {
    S_SWEEP   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_HEAD    = 9'b000000100,
    S_NODE    = 9'b000001000,
    S_MISS    = 9'b000010000,
    S_RL_HASH = 9'b000100000,
    S_RL_HEAD = 9'b001000000,
    S_RL_LINK = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t            state_r, ret_r, state_nxt;
  logic [LOG_W-1:0]  log2_r;
  logic [CNT_W-1:0]  count_r;
  logic [MAXL-1:0]   sw_r, bkt_r, hash_r;
  logic [NODE_W-1:0] ri_r;
  logic [1:0]        op_r;
  logic [31:0]       key_r;
  logic [NODE_W:0]   head_r;
  logic [2:0]        st_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  // Head entries and links carry a valid bit above the node index.
  logic [NODE_W:0]   heads_mem [BKT_N];
  logic [31:0]       key_mem   [NODE_CAPACITY];
  logic [NODE_W:0]   link_mem  [NODE_CAPACITY];
  logic [MAXL-1:0]   hash_mem  [NODE_CAPACITY];

  logic              heads_we, link_we, node_we;
  logic [MAXL-1:0]   heads_waddr, heads_raddr;
  logic [NODE_W:0]   heads_wdata, heads_q, link_wdata, link_q;
  logic [NODE_W-1:0] link_waddr, node_raddr;
  logic [31:0]       key_q;
  logic [MAXL-1:0]   hash_q;

  logic [MAXL-1:0]   mask, q_bucket;
  logic              can_add, grow_ok, emit_ok, rl_last;
  logic [LOG_W-1:0]  cfg_sat;
  logic [LOAD_W-1:0] load_lhs, load_rhs;

  assign mask     = ~({MAXL{1'b1}} << log2_r);
  assign q_bucket = q_item.hash[MAXL-1:0] & mask;
  assign can_add  = count_r != CNT_W'(NODE_CAPACITY);
  assign load_lhs = LOAD_W'({count_r + 1'b1, 2'b00});
  assign load_rhs = LOAD_W'(3) << log2_r;
  assign grow_ok  = (load_lhs > load_rhs) && (log2_r != LOG_W'(MAXL));
  assign emit_ok  = !out_valid_r || !out_stall;
  assign rl_last  = (CNT_W'(ri_r) + 1'b1) == count_r;
  assign cfg_sat  = (32'(cfg_value) > MAXL) ? LOG_W'(MAXL) : LOG_W'(cfg_value);
  assign pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    heads_raddr = (state_r == S_RL_HEAD) ? (hash_q & mask) : q_bucket;
    node_raddr  = (state_r == S_HEAD) ? heads_q[NODE_W-1:0] : link_q[NODE_W-1:0];
    heads_we    = 1'b0;
    heads_waddr = sw_r;
    heads_wdata = '0;
    link_we     = 1'b0;
    link_waddr  = ri_r;
    link_wdata  = heads_q;
    node_we     = 1'b0;
    if (state_r == S_SWEEP) begin
      heads_we = 1'b1;
    end else if (state_r == S_MISS && op_r == OP_INSERT && can_add) begin
      heads_we    = 1'b1;
      heads_waddr = bkt_r;
      heads_wdata = {1'b1, count_r[NODE_W-1:0]};
      link_we     = 1'b1;
      link_waddr  = count_r[NODE_W-1:0];
      link_wdata  = head_r;
      node_we     = 1'b1;
    end else if (state_r == S_RL_LINK) begin
      heads_we    = 1'b1;
      heads_waddr = bkt_r;
      heads_wdata = {1'b1, ri_r};
      link_we     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_waddr] <= heads_wdata;
    heads_q <= heads_mem[heads_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (node_we) begin
      key_mem[count_r[NODE_W-1:0]]  <= key_r;
      hash_mem[count_r[NODE_W-1:0]] <= hash_r;
    end
    link_q <= link_mem[node_raddr];
    key_q  <= key_mem[node_raddr];
    hash_q <= hash_mem[ri_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP:   if (sw_r == mask) state_nxt = ret_r;
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_INSERT || q_item.op == OP_LOOKUP) state_nxt = S_HEAD;
          else if (q_item.op == OP_CLEAR)                        state_nxt = S_SWEEP;
          else                                                   state_nxt = S_EMIT;
        end
      end
      S_HEAD:    state_nxt = heads_q[NODE_W] ? S_NODE : S_MISS;
      S_NODE: begin
        if (key_q == key_r)    state_nxt = S_EMIT;
        else if (!link_q[NODE_W]) state_nxt = S_MISS;
      end
      S_MISS: begin
        if (op_r == OP_INSERT && can_add && grow_ok) state_nxt = S_SWEEP;
        else                                         state_nxt = S_EMIT;
      end
      S_RL_HASH: state_nxt = S_RL_HEAD;
      S_RL_HEAD: state_nxt = S_RL_LINK;
      S_RL_LINK: state_nxt = rl_last ? S_EMIT : S_RL_HASH;
      S_EMIT:    if (emit_ok) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      ret_r       <= S_IDLE;
      sw_r        <= '0;
      log2_r      <= LOG_W'(RST_LOG);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_we) begin
      // A register write starts an empty table of the new size.
      state_r <= S_SWEEP;
      ret_r   <= S_IDLE;
      sw_r    <= '0;
      log2_r  <= cfg_sat;
      count_r <= '0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_SWEEP: sw_r <= sw_r + 1'b1;
        S_IDLE: begin
          if (q_valid && q_item.op == OP_CLEAR) begin
            count_r <= '0;
            sw_r    <= '0;
            ret_r   <= S_EMIT;
            st_r    <= ST_CLEARED;
          end else if (q_valid) begin
            st_r <= ST_NOT_FOUND;
          end
        end
        S_NODE: begin
          if (key_q == key_r) st_r <= (op_r == OP_INSERT) ? ST_CONTAINED : ST_FOUND;
        end
        S_MISS: begin
          if (op_r != OP_INSERT) begin
            st_r <= ST_NOT_FOUND;
          end else if (!can_add) begin
            st_r <= ST_FULL;
          end else begin
            count_r <= count_r + 1'b1;
            if (grow_ok) begin
              st_r   <= ST_RESIZED;
              log2_r <= log2_r + 1'b1;
              sw_r   <= '0;
              ri_r   <= '0;
              ret_r  <= S_RL_HASH;
            end else begin
              st_r <= ST_ADDED;
            end
          end
        end
        S_RL_LINK: ri_r <= ri_r + 1'b1;
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_count_r  <= count_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r   <= q_item.op;
      key_r  <= q_item.key;
      hash_r <= q_item.hash[MAXL-1:0];
      bkt_r  <= q_bucket;
    end
    if (state_r == S_RL_HEAD) bkt_r <= hash_q & mask;
    if (state_r == S_HEAD) head_r <= heads_q;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_count = 11'(out_count_r);

endmodule
